@@ src/ltcn_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle face test package
// Shared types and constants of the triangle centroid and face normal block.
// ----------------------------------------------------------------------------
package ltcn_pkg;

    localparam int IdxW   = 12;
    localparam int CoordW = 24;
    localparam int NormW  = 16;
    localparam int ThrW   = 23;
    localparam int T2W    = 2 * ThrW;
    localparam int MagW   = 30;
    localparam int RadW   = 2 * MagW + 2;
    localparam int RootW  = RadW / 2;
    localparam int QuotW  = 15;

    localparam logic [QuotW-1:0] NormOne = 15'd16384;
    localparam logic [26:0]      Recip3  = 27'd89478486;

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdTest  = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [IdxW-1:0]          vertex_address;
        logic [IdxW-1:0]          index_a;
        logic [IdxW-1:0]          index_b;
        logic [IdxW-1:0]          index_c;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
    } cmd_t;

    typedef struct packed {
        logic signed [CoordW-1:0] centroid_x;
        logic signed [CoordW-1:0] centroid_y;
        logic signed [CoordW-1:0] centroid_z;
        logic signed [NormW-1:0]  normal_x;
        logic signed [NormW-1:0]  normal_y;
        logic signed [NormW-1:0]  normal_z;
    } res_t;

    // Index 0 is x, 1 is y, 2 is z.
    typedef logic [2:0][CoordW-1:0] vertex_t;

    typedef struct packed {
        logic [2:0][CoordW-1:0] cen;
        logic [2:0]             neg;
        logic [2:0][MagW-1:0]   mag;
        logic                   zero;
    } side_t;

endpackage

@@ src/large_triangle_centroid_normal.sv @@
// ----------------------------------------------------------------------------
// Triangle centroid and face normal
// Vertex memory loaded by write transactions; test transactions read three
// corners, drop small triangles and return the centroid and unit normal.
//
//   Channel  Handshake           Payload
//   cmd      cmd_valid/cmd_stall ltcn_pkg::cmd_t, vertex write or triangle test
//   res      res_valid/res_stall ltcn_pkg::res_t, centroid and normal
//   cfg      cfg_valid/cfg_ready face_threshold, 23 bits
//
// One transaction is accepted per cycle while cmd_stall is low; a kept triangle
// reaches res through the bit-per-stage root and divider pipes.
// The vertex store needs no clearing pass after reset and reads of unwritten
// entries return undefined data.
// An output register and a skid register sit at the end; cmd_stall is high
// only while the skid register holds a transaction.
// ----------------------------------------------------------------------------
module large_triangle_centroid_normal #(
    parameter int VERTEX_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  ltcn_pkg::cmd_t                cmd,
    output logic                          res_valid,
    input  logic                          res_stall,
    output ltcn_pkg::res_t                res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ltcn_pkg::ThrW-1:0]     cfg_data
);

    localparam int  IdxW   = ltcn_pkg::IdxW;
    localparam int  CoordW = ltcn_pkg::CoordW;
    localparam int  MagW   = ltcn_pkg::MagW;
    localparam int  T2W    = ltcn_pkg::T2W;
    localparam int  AddrW  = $clog2(VERTEX_DEPTH);
    localparam bit  NeedMod = VERTEX_DEPTH < (1 << ltcn_pkg::IdxW);
    localparam int  Recip  = NeedMod ? ((1 << 24) + VERTEX_DEPTH - 1) / VERTEX_DEPTH : 0;

    function automatic logic [IdxW-1:0] quot(input logic [IdxW-1:0] x);
        logic [39:0] p;
        p = 40'(x) * 40'(Recip);
        return IdxW'(p >> 24);
    endfunction

    function automatic logic [AddrW-1:0] reduce(input logic [IdxW-1:0] x,
                                                input logic [IdxW-1:0] q);
        logic [31:0] d;
        d = 32'(x) - 32'(q) * 32'(VERTEX_DEPTH);
        return AddrW'(d);
    endfunction

    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;
    ltcn_pkg::res_t skid_data_reg;
    ltcn_pkg::res_t out_data_reg;

    assign adv       = ~skid_valid_reg;
    assign cmd_stall = skid_valid_reg;
    assign cfg_ready = 1'b1;

    // Configuration
    logic [ltcn_pkg::ThrW-1:0] thr_reg;
    logic [T2W-1:0]            t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            t2_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            t2_reg <= T2W'(thr_reg) * T2W'(thr_reg);
        end
    end

    // Stage 1: index reduction
    logic              s1_valid_reg;
    ltcn_pkg::cmd_t    s1_cmd_reg;
    logic [IdxW-1:0]   s1_q_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg  <= cmd;
            s1_q_reg[0] <= quot(cmd.index_a);
            s1_q_reg[1] <= quot(cmd.index_b);
            s1_q_reg[2] <= quot(cmd.index_c);
            s1_q_reg[3] <= quot(cmd.vertex_address);
        end
    end

    logic [AddrW-1:0]  addr_a;
    logic [AddrW-1:0]  addr_b;
    logic [AddrW-1:0]  addr_c;
    logic [AddrW-1:0]  addr_w;
    logic              wr_en;
    ltcn_pkg::vertex_t wr_data;
    ltcn_pkg::vertex_t va;
    ltcn_pkg::vertex_t vb;
    ltcn_pkg::vertex_t vc;

    always_comb
    begin
        addr_a  = reduce(s1_cmd_reg.index_a, s1_q_reg[0]);
        addr_b  = reduce(s1_cmd_reg.index_b, s1_q_reg[1]);
        addr_c  = reduce(s1_cmd_reg.index_c, s1_q_reg[2]);
        addr_w  = reduce(s1_cmd_reg.vertex_address, s1_q_reg[3]);
        wr_en   = adv && s1_valid_reg && (s1_cmd_reg.command == ltcn_pkg::CmdWrite);
        wr_data = {s1_cmd_reg.coord_z, s1_cmd_reg.coord_y, s1_cmd_reg.coord_x};
    end

    ltcn_vstore #(
        .DEPTH (VERTEX_DEPTH),
        .AW    (AddrW)
    ) u_store_ab (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (addr_w),
        .wr_data  (wr_data),
        .rd_en    (adv),
        .rd0_addr (addr_a),
        .rd1_addr (addr_b),
        .rd0_data (va),
        .rd1_data (vb)
    );

    ltcn_vstore #(
        .DEPTH (VERTEX_DEPTH),
        .AW    (AddrW)
    ) u_store_c (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (addr_w),
        .wr_data  (wr_data),
        .rd_en    (adv),
        .rd0_addr (addr_c),
        .rd1_addr (addr_c),
        .rd0_data (vc),
        .rd1_data ()
    );

    // Stage 2: memory data; edges and corner sums
    logic s2_valid_reg;
    logic signed [24:0] e_next   [3][3];
    logic signed [25:0] sum_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e_next[0][k] = 25'($signed(vb[k])) - 25'($signed(va[k]));
            e_next[1][k] = 25'($signed(vc[k])) - 25'($signed(va[k]));
            e_next[2][k] = 25'($signed(vc[k])) - 25'($signed(vb[k]));
            sum_next[k]  = 26'($signed(va[k])) + 26'($signed(vb[k]))
                         + 26'($signed(vc[k]));
        end
    end

    // Stage 3: squares, cross product terms, centroid scaling
    logic               s3_valid_reg;
    logic signed [24:0] s3_e_reg   [3][3];
    logic signed [25:0] s3_sum_reg [3];

    logic [24:0]        emag      [3][3];
    logic [48:0]        sq_next   [3][3];
    logic signed [49:0] crp_next  [3];
    logic signed [49:0] crn_next  [3];
    logic [25:0]        cmag      [3];
    logic [53:0]        cprod     [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                emag[j][k] = s3_e_reg[j][k][24] ? 25'(-s3_e_reg[j][k])
                                                : 25'(s3_e_reg[j][k]);
                sq_next[j][k] = 49'(emag[j][k]) * 49'(emag[j][k]);
            end
        end
        crp_next[0] = 50'(s3_e_reg[0][1]) * 50'(s3_e_reg[1][2]);
        crn_next[0] = 50'(s3_e_reg[0][2]) * 50'(s3_e_reg[1][1]);
        crp_next[1] = 50'(s3_e_reg[0][2]) * 50'(s3_e_reg[1][0]);
        crn_next[1] = 50'(s3_e_reg[0][0]) * 50'(s3_e_reg[1][2]);
        crp_next[2] = 50'(s3_e_reg[0][0]) * 50'(s3_e_reg[1][1]);
        crn_next[2] = 50'(s3_e_reg[0][1]) * 50'(s3_e_reg[1][0]);
        for (int k = 0; k < 3; k++)
        begin
            cmag[k]  = (s3_sum_reg[k][25] ? 26'(-s3_sum_reg[k]) : 26'(s3_sum_reg[k]))
                     + 26'd1;
            cprod[k] = 54'(cmag[k]) * 54'(ltcn_pkg::Recip3);
        end
    end

    // Stage 4: edge lengths, cross product, signed centroid
    logic               s4_valid_reg;
    logic [48:0]        s4_sq_reg  [3][3];
    logic signed [49:0] s4_crp_reg [3];
    logic signed [49:0] s4_crn_reg [3];
    logic [CoordW-1:0]  s4_cq_reg  [3];
    logic [2:0]         s4_cneg_reg;

    logic [50:0]            len_next [3];
    logic signed [50:0]     cr_next  [3];
    logic [2:0][CoordW-1:0] cen_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            len_next[j] = 51'(s4_sq_reg[j][0]) + 51'(s4_sq_reg[j][1])
                        + 51'(s4_sq_reg[j][2]);
        end
        for (int k = 0; k < 3; k++)
        begin
            cr_next[k]  = 51'(s4_crp_reg[k]) - 51'(s4_crn_reg[k]);
            cen_next[k] = s4_cneg_reg[k] ? (CoordW'(0) - s4_cq_reg[k]) : s4_cq_reg[k];
        end
    end

    // Stage 5: edge test and cross product magnitudes
    logic                   s5_valid_reg;
    logic [50:0]            s5_len_reg [3];
    logic signed [50:0]     s5_cr_reg  [3];
    logic [2:0][CoordW-1:0] s5_cen_reg;

    logic        edge_ok_next;
    logic [48:0] crm_next [3];
    logic [2:0]  nneg_next;

    always_comb
    begin
        edge_ok_next = (s5_len_reg[0] >= 51'(t2_reg)) && (s5_len_reg[1] >= 51'(t2_reg))
                    && (s5_len_reg[2] >= 51'(t2_reg));
        for (int k = 0; k < 3; k++)
        begin
            crm_next[k]  = s5_cr_reg[k][50] ? 49'(-s5_cr_reg[k]) : 49'(s5_cr_reg[k]);
            nneg_next[k] = s5_cr_reg[k][50];
        end
    end

    // Stage 6: partial squares and normalising shift
    logic                   s6_valid_reg;
    logic                   s6_edge_ok_reg;
    logic [48:0]            s6_crm_reg [3];
    logic [2:0]             s6_nneg_reg;
    logic [2:0][CoordW-1:0] s6_cen_reg;

    logic [47:0] hh_next [3];
    logic [48:0] hl_next [3];
    logic [49:0] ll_next [3];
    logic [48:0] orv;
    logic [4:0]  sh_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hh_next[k] = 48'(s6_crm_reg[k][48:25]) * 48'(s6_crm_reg[k][48:25]);
            hl_next[k] = 49'(s6_crm_reg[k][48:25]) * 49'(s6_crm_reg[k][24:0]);
            ll_next[k] = 50'(s6_crm_reg[k][24:0]) * 50'(s6_crm_reg[k][24:0]);
        end
        orv     = s6_crm_reg[0] | s6_crm_reg[1] | s6_crm_reg[2];
        sh_next = '0;
        for (int i = 0; i < 49 - MagW; i++)
        begin
            if (orv[MagW + i])
            begin
                sh_next = 5'(i + 1);
            end
        end
    end

    // Stage 7: squared magnitudes and shifted magnitudes
    logic                   s7_valid_reg;
    logic                   s7_edge_ok_reg;
    logic [47:0]            s7_hh_reg [3];
    logic [48:0]            s7_hl_reg [3];
    logic [49:0]            s7_ll_reg [3];
    logic [48:0]            s7_crm_reg [3];
    logic [4:0]             s7_sh_reg;
    logic [2:0]             s7_nneg_reg;
    logic [2:0][CoordW-1:0] s7_cen_reg;

    logic [97:0]            sqm_next [3];
    logic [2:0][MagW-1:0]   sx_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sqm_next[k] = (98'(s7_hh_reg[k]) << 50) + (98'(s7_hl_reg[k]) << 26)
                        + 98'(s7_ll_reg[k]);
            sx_next[k]  = MagW'(s7_crm_reg[k] >> s7_sh_reg);
        end
    end

    // Stage 8: cross product length squared and scaled squares
    logic                   s8_valid_reg;
    logic                   s8_edge_ok_reg;
    logic [97:0]            s8_sqm_reg [3];
    logic [2:0][MagW-1:0]   s8_sx_reg;
    logic [2:0]             s8_nneg_reg;
    logic [2:0][CoordW-1:0] s8_cen_reg;

    logic [99:0]            csq_next;
    logic [2*MagW-1:0]      sxsq_next [3];

    always_comb
    begin
        csq_next = 100'(s8_sqm_reg[0]) + 100'(s8_sqm_reg[1]) + 100'(s8_sqm_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            sxsq_next[k] = (2*MagW)'(s8_sx_reg[k]) * (2*MagW)'(s8_sx_reg[k]);
        end
    end

    // Stage 9: area test and radicand
    logic                   s9_valid_reg;
    logic                   s9_edge_ok_reg;
    logic [99:0]            s9_csq_reg;
    logic [2*MagW-1:0]      s9_sxsq_reg [3];
    logic [2:0][MagW-1:0]   s9_sx_reg;
    logic [2:0]             s9_nneg_reg;
    logic [2:0][CoordW-1:0] s9_cen_reg;

    logic                        keep_next;
    logic [ltcn_pkg::RadW-1:0]   rad_next;
    ltcn_pkg::side_t             side_next;

    always_comb
    begin
        keep_next = s9_valid_reg && s9_edge_ok_reg
                 && (s9_csq_reg >= (100'(t2_reg) << 10));
        rad_next  = ltcn_pkg::RadW'(s9_sxsq_reg[0]) + ltcn_pkg::RadW'(s9_sxsq_reg[1])
                  + ltcn_pkg::RadW'(s9_sxsq_reg[2]);
        side_next.cen  = s9_cen_reg;
        side_next.neg  = s9_nneg_reg;
        side_next.mag  = s9_sx_reg;
        side_next.zero = (s9_sx_reg == '0);
    end

    logic                      s10_valid_reg;
    logic [ltcn_pkg::RadW-1:0] s10_rad_reg;
    ltcn_pkg::side_t           s10_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg  <= s1_valid_reg && (s1_cmd_reg.command == ltcn_pkg::CmdTest);
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= keep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_e_reg   <= e_next;
            s3_sum_reg <= sum_next;

            s4_sq_reg  <= sq_next;
            s4_crp_reg <= crp_next;
            s4_crn_reg <= crn_next;
            for (int k = 0; k < 3; k++)
            begin
                s4_cq_reg[k]   <= CoordW'(cprod[k] >> 28);
                s4_cneg_reg[k] <= s3_sum_reg[k][25];
            end

            s5_len_reg <= len_next;
            s5_cr_reg  <= cr_next;
            s5_cen_reg <= cen_next;

            s6_edge_ok_reg <= edge_ok_next;
            s6_crm_reg     <= crm_next;
            s6_nneg_reg    <= nneg_next;
            s6_cen_reg     <= s5_cen_reg;

            s7_edge_ok_reg <= s6_edge_ok_reg;
            s7_hh_reg      <= hh_next;
            s7_hl_reg      <= hl_next;
            s7_ll_reg      <= ll_next;
            s7_crm_reg     <= s6_crm_reg;
            s7_sh_reg      <= sh_next;
            s7_nneg_reg    <= s6_nneg_reg;
            s7_cen_reg     <= s6_cen_reg;

            s8_edge_ok_reg <= s7_edge_ok_reg;
            s8_sqm_reg     <= sqm_next;
            s8_sx_reg      <= sx_next;
            s8_nneg_reg    <= s7_nneg_reg;
            s8_cen_reg     <= s7_cen_reg;

            s9_edge_ok_reg <= s8_edge_ok_reg;
            s9_csq_reg     <= csq_next;
            s9_sxsq_reg    <= sxsq_next;
            s9_sx_reg      <= s8_sx_reg;
            s9_nneg_reg    <= s8_nneg_reg;
            s9_cen_reg     <= s8_cen_reg;

            s10_rad_reg    <= rad_next;
            s10_side_reg   <= side_next;
        end
    end

    // Square root and division
    logic                       root_valid;
    logic [ltcn_pkg::RootW-1:0] root;
    ltcn_pkg::side_t            root_side;
    logic                       pipe_valid;
    ltcn_pkg::res_t             pipe_data;

    ltcn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .arg_valid (s10_valid_reg),
        .arg_rad   (s10_rad_reg),
        .arg_side  (s10_side_reg),
        .ret_valid (root_valid),
        .ret_root  (root),
        .ret_side  (root_side)
    );

    ltcn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .arg_valid (root_valid),
        .arg_root  (root),
        .arg_side  (root_side),
        .ret_valid (pipe_valid),
        .ret       (pipe_data)
    );

    // Output register and skid register
    logic out_free;

    assign out_free = ~out_valid_reg | ~res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_valid;
            end
        end
        else if (pipe_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_data_reg <= pipe_data;
            end
        end
        else if (!skid_valid_reg)
        begin
            skid_data_reg <= pipe_data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

endmodule

@@ src/ltcn_vstore.sv @@
// ----------------------------------------------------------------------------
// Vertex store
// Synchronous vertex memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ltcn_vstore #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  ltcn_pkg::vertex_t wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd0_addr,
    input  logic [AW-1:0]     rd1_addr,
    output ltcn_pkg::vertex_t rd0_data,
    output ltcn_pkg::vertex_t rd1_data
);

    ltcn_pkg::vertex_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd0_data <= mem[rd0_addr];
            rd1_data <= mem[rd1_addr];
        end
    end

endmodule

@@ src/ltcn_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; a new radicand may enter on every enabled cycle.
// ----------------------------------------------------------------------------
module ltcn_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           arg_valid,
    input  logic [ltcn_pkg::RadW-1:0]      arg_rad,
    input  ltcn_pkg::side_t                arg_side,
    output logic                           ret_valid,
    output logic [ltcn_pkg::RootW-1:0]     ret_root,
    output ltcn_pkg::side_t                ret_side
);

    localparam int Steps = ltcn_pkg::RootW;
    localparam int RemW  = ltcn_pkg::RootW + 3;
    localparam int RadW  = ltcn_pkg::RadW;
    localparam int RootW = ltcn_pkg::RootW;

    logic              valid_reg [Steps];
    logic [RemW-1:0]   rem_reg   [Steps];
    logic [RootW-1:0]  root_reg  [Steps];
    logic [RadW-1:0]   rad_reg   [Steps];
    ltcn_pkg::side_t   side_reg  [Steps];

    for (genvar i = 0; i < Steps; i++)
    begin : g_step
        logic             cur_valid;
        logic [RemW-1:0]  cur_rem;
        logic [RootW-1:0] cur_root;
        logic [RadW-1:0]  cur_rad;
        ltcn_pkg::side_t  cur_side;
        logic [RemW-1:0]  rem_sh;
        logic [RemW-1:0]  trial;
        logic             ge;
        logic [RemW-1:0]  rem_next;
        logic [RootW-1:0] root_next;

        if (i == 0)
        begin : g_first
            assign cur_valid = arg_valid;
            assign cur_rem   = '0;
            assign cur_root  = '0;
            assign cur_rad   = arg_rad;
            assign cur_side  = arg_side;
        end
        else
        begin : g_next
            assign cur_valid = valid_reg[i-1];
            assign cur_rem   = rem_reg[i-1];
            assign cur_root  = root_reg[i-1];
            assign cur_rad   = rad_reg[i-1];
            assign cur_side  = side_reg[i-1];
        end

        always_comb
        begin
            rem_sh    = {cur_rem[RemW-3:0], cur_rad[RadW-1 -: 2]};
            trial     = RemW'({cur_root, 2'b01});
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {cur_root[RootW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= {cur_rad[RadW-3:0], 2'b00};
                side_reg[i] <= cur_side;
            end
        end
    end

    assign ret_valid = valid_reg[Steps-1];
    assign ret_root  = root_reg[Steps-1];
    assign ret_side  = side_reg[Steps-1];

endmodule

@@ src/ltcn_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined normal divider
// Divides each scaled cross product magnitude by the root, one quotient bit
// per stage, and formats the final result transaction.
// ----------------------------------------------------------------------------
module ltcn_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           arg_valid,
    input  logic [ltcn_pkg::RootW-1:0]     arg_root,
    input  ltcn_pkg::side_t                arg_side,
    output logic                           ret_valid,
    output ltcn_pkg::res_t                 ret
);

    localparam int Steps = ltcn_pkg::QuotW;
    localparam int RootW = ltcn_pkg::RootW;
    localparam int RemW  = ltcn_pkg::MagW + ltcn_pkg::QuotW + 1;
    localparam int QuotW = ltcn_pkg::QuotW;
    localparam int NormW = ltcn_pkg::NormW;

    logic              valid_reg [Steps];
    logic [RemW-1:0]   rem_reg   [Steps][3];
    logic [QuotW-1:0]  quot_reg  [Steps][3];
    logic [RootW-1:0]  root_reg  [Steps];
    ltcn_pkg::side_t   side_reg  [Steps];

    logic [RootW-1:0]  root_first;
    logic [RemW-1:0]   num_first [3];

    always_comb
    begin
        root_first = (arg_root == '0) ? RootW'(1) : arg_root;
        for (int k = 0; k < 3; k++)
        begin
            num_first[k] = (RemW'(arg_side.mag[k]) << (QuotW - 1))
                         + RemW'(root_first >> 1);
        end
    end

    for (genvar i = 0; i < Steps; i++)
    begin : g_step
        logic             cur_valid;
        logic [RemW-1:0]  cur_rem  [3];
        logic [QuotW-1:0] cur_quot [3];
        logic [RootW-1:0] cur_root;
        ltcn_pkg::side_t  cur_side;
        logic [RemW-1:0]  dv;
        logic [RemW-1:0]  rem_next  [3];
        logic [QuotW-1:0] quot_next [3];

        if (i == 0)
        begin : g_first
            assign cur_valid = arg_valid;
            assign cur_root  = root_first;
            assign cur_side  = arg_side;
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign cur_rem[k]  = num_first[k];
                assign cur_quot[k] = '0;
            end
        end
        else
        begin : g_next
            assign cur_valid = valid_reg[i-1];
            assign cur_root  = root_reg[i-1];
            assign cur_side  = side_reg[i-1];
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign cur_rem[k]  = rem_reg[i-1][k];
                assign cur_quot[k] = quot_reg[i-1][k];
            end
        end

        always_comb
        begin
            dv = RemW'(cur_root) << (Steps - 1 - i);
            for (int k = 0; k < 3; k++)
            begin
                if (cur_rem[k] >= dv)
                begin
                    rem_next[k]  = cur_rem[k] - dv;
                    quot_next[k] = {cur_quot[k][QuotW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k]  = cur_rem[k];
                    quot_next[k] = {cur_quot[k][QuotW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[i][k]  <= rem_next[k];
                    quot_reg[i][k] <= quot_next[k];
                end
                root_reg[i] <= cur_root;
                side_reg[i] <= cur_side;
            end
        end
    end

    logic [QuotW-1:0] clamp [3];
    logic [NormW-1:0] norm  [3];
    ltcn_pkg::side_t  last_side;

    always_comb
    begin
        last_side = side_reg[Steps-1];
        for (int k = 0; k < 3; k++)
        begin
            clamp[k] = (quot_reg[Steps-1][k] > ltcn_pkg::NormOne)
                     ? ltcn_pkg::NormOne : quot_reg[Steps-1][k];
            if (last_side.zero)
            begin
                norm[k] = '0;
            end
            else if (last_side.neg[k])
            begin
                norm[k] = NormW'(0) - NormW'(clamp[k]);
            end
            else
            begin
                norm[k] = NormW'(clamp[k]);
            end
        end
        ret.centroid_x = last_side.cen[0];
        ret.centroid_y = last_side.cen[1];
        ret.centroid_z = last_side.cen[2];
        ret.normal_x   = norm[0];
        ret.normal_y   = norm[1];
        ret.normal_z   = norm[2];
    end

    assign ret_valid = valid_reg[Steps-1];

endmodule
